// ----- rtl/trb_pkg.sv -----
package trb_pkg;

    localparam int DEPTH      = 32;
    localparam int STAMP_BITS = 48;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LAG_BITS   = 8;
    localparam int FILL_BITS  = 6;
    localparam int CMP_W      = (CNT_W > LAG_BITS) ? CNT_W : LAG_BITS;

    // input item bit positions inside tdata
    localparam int IN_STAMP_LO = 2;
    localparam int IN_FDEL     = IN_STAMP_LO + STAMP_BITS;
    localparam int IN_LVALID   = IN_FDEL + 1;
    localparam int IN_LAG_LO   = IN_LVALID + 1;
    localparam int IN_BITS     = IN_LAG_LO + LAG_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // result item bit positions inside tdata
    localparam int OUT_STAMP_LO = 1;
    localparam int OUT_FOUND    = OUT_STAMP_LO + STAMP_BITS;
    localparam int OUT_OVF      = OUT_FOUND + 1;
    localparam int OUT_FILL_LO  = OUT_OVF + 1;
    localparam int OUT_BITS     = OUT_FILL_LO + FILL_BITS;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                  resync;
        logic                  stamp_valid;
        logic [STAMP_BITS-1:0] stamp;
        logic                  frame_delivered;
        logic                  lag_valid;
        logic [LAG_BITS-1:0]   decoder_lag;
    } in_item_t;

    typedef struct packed {
        logic                  frame_out;
        logic [STAMP_BITS-1:0] frame_stamp;
        logic                  stamp_found;
        logic                  overflow;
        logic [FILL_BITS-1:0]  fill_count;
    } result_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [STAMP_BITS-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } ram_req_t;

endpackage

// ----- rtl/trb_ram.sv -----
module trb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/trb_engine.sv -----
module trb_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  trb_pkg::in_item_t                in_item,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    output trb_pkg::ram_req_t                ram_req,
    input  logic [trb_pkg::STAMP_BITS-1:0]   ram_rdata,
    input  logic                             res_ready,
    output logic                             res_load,
    output trb_pkg::result_t                 res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CMP  = 3'd1;
    localparam logic [2:0] S_INS_PUT  = 3'd2;
    localparam logic [2:0] S_POP_RD   = 3'd3;
    localparam logic [2:0] S_POP_DATA = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;

    logic [2:0]                         state_reg, state_next;
    logic [trb_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [trb_pkg::ADDR_W-1:0]         idx_reg, idx_next;
    logic                               enable_reg;
    logic [trb_pkg::STAMP_BITS-1:0]     stamp_reg, stamp_next;
    logic                               fdel_reg, fdel_next;
    logic                               lvalid_reg, lvalid_next;
    logic [trb_pkg::LAG_BITS-1:0]       lag_reg, lag_next;
    logic                               ovf_reg, ovf_next;
    logic                               found_reg, found_next;
    logic [trb_pkg::STAMP_BITS-1:0]     fstamp_reg, fstamp_next;

    logic [trb_pkg::CNT_W-1:0]          cnt_eff;
    logic [trb_pkg::CNT_W-1:0]          cnt_eff_m1;
    logic [trb_pkg::CNT_W-1:0]          count_m1;
    logic [trb_pkg::CNT_W-1:0]          count_trim;

    assign cnt_eff    = in_item.resync ? '0 : count_reg;
    assign cnt_eff_m1 = cnt_eff - trb_pkg::CNT_W'(1);
    assign count_m1   = count_reg - trb_pkg::CNT_W'(1);

    // cut to the decoder lag when it is valid and not above the count
    always_comb
    begin
        count_trim = count_reg;
        if (lvalid_reg &&
            (trb_pkg::CMP_W'(lag_reg) <= trb_pkg::CMP_W'(count_reg)))
        begin
            count_trim = trb_pkg::CNT_W'(lag_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        stamp_next    = stamp_reg;
        fdel_next     = fdel_reg;
        lvalid_next   = lvalid_reg;
        lag_next      = lag_reg;
        ovf_next      = ovf_reg;
        found_next    = found_reg;
        fstamp_next   = fstamp_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = stamp_reg;
        ram_req.raddr = idx_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    stamp_next  = in_item.stamp;
                    fdel_next   = in_item.frame_delivered;
                    lvalid_next = in_item.lag_valid;
                    lag_next    = in_item.decoder_lag;
                    ovf_next    = 1'b0;
                    found_next  = 1'b0;
                    fstamp_next = '0;
                    count_next  = cnt_eff;
                    state_next  = S_POP_RD;
                    if (enable_reg && in_item.stamp_valid)
                    begin
                        if (cnt_eff >= trb_pkg::CNT_W'(trb_pkg::DEPTH))
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (cnt_eff == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            ram_req.raddr = cnt_eff_m1[trb_pkg::ADDR_W-1:0];
                            idx_next      = cnt_eff_m1[trb_pkg::ADDR_W-1:0];
                            state_next    = S_INS_CMP;
                        end
                    end
                end
            end

            // walk down from the tail, shifting smaller entries up by one
            S_INS_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg + trb_pkg::ADDR_W'(1);
                if ($signed(ram_rdata) < $signed(stamp_reg))
                begin
                    ram_req.wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ram_req.raddr = idx_reg - trb_pkg::ADDR_W'(1);
                        idx_next      = idx_reg - trb_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    // equal or larger entry: new stamp goes just after it
                    ram_req.wdata = stamp_reg;
                    count_next    = count_reg + trb_pkg::CNT_W'(1);
                    state_next    = S_POP_RD;
                end
            end

            S_INS_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = stamp_reg;
                count_next    = count_reg + trb_pkg::CNT_W'(1);
                state_next    = S_POP_RD;
            end

            S_POP_RD:
            begin
                state_next = S_FIN;
                if (enable_reg && fdel_reg)
                begin
                    if (count_reg != '0)
                    begin
                        ram_req.raddr = count_m1[trb_pkg::ADDR_W-1:0];
                        count_next    = count_m1;
                        state_next    = S_POP_DATA;
                    end
                    else
                    begin
                        count_next = count_trim;
                    end
                end
            end

            S_POP_DATA:
            begin
                fstamp_next = ram_rdata;
                found_next  = 1'b1;
                count_next  = count_trim;
                state_next  = S_FIN;
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.frame_out   = fdel_reg;
    assign res.frame_stamp = fstamp_reg;
    assign res.stamp_found = found_reg;
    assign res.overflow    = ovf_reg;
    assign res.fill_count  = trb_pkg::FILL_BITS'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        stamp_reg  <= stamp_next;
        fdel_reg   <= fdel_next;
        lvalid_reg <= lvalid_next;
        lag_reg    <= lag_next;
        ovf_reg    <= ovf_next;
        found_reg  <= found_next;
        fstamp_reg <= fstamp_next;
    end

endmodule

// ----- rtl/trb_out.sv -----
module trb_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  trb_pkg::result_t                  res,
    output logic                              can_load,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [trb_pkg::OUT_TDATA_W-1:0]   m_data
);

    logic             valid_reg, valid_next;
    trb_pkg::result_t res_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {{(trb_pkg::OUT_TDATA_W - trb_pkg::OUT_BITS){1'b0}},
                      res_reg.fill_count, res_reg.overflow, res_reg.stamp_found,
                      res_reg.frame_stamp, res_reg.frame_out};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- rtl/timestamp_reorder_buffer_unit.sv -----
// Timestamp reorder buffer: keeps packet timestamps sorted (largest first) in a
// 32-entry memory and hands the smallest one to each delivered frame.
// Input channel s_axis_*: one item per decoded packet; an item with resync set
// empties the buffer first, a valid stamp is inserted after any equal entries,
// and a delivered frame pops the smallest stamp, then the count is cut to the
// decoder lag when that lag is valid and not above the count.
// Output channel m_axis_*: exactly one result item per input item.
// Config: cfg_we/cfg_wdata write reorder_enable (reset 0); while it is 0 the
// buffer is left alone except for resync.
// Steps per item: accept, then any insertion (walking down from the tail,
// shifting each smaller entry up, until the new stamp is written), then the
// pop read and its data when a frame pops a stamp, then the result hand-off.
// The insertion walk runs over the store's read/write ports; one item is in
// work at a time and s_axis_tready is high only when idle.
// The result sits in an output register, so the next item is taken while
// a result still waits; if m_axis_tready stays low the engine holds its next
// result and stops taking items. Reset empties the buffer (count to zero) and
// clears reorder_enable; memory contents are not cleared.
module timestamp_reorder_buffer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] resync, [1] stamp_valid, [49:2] stamp, [50] frame_delivered,
    // [51] lag_valid, [59:52] decoder_lag, rest zero
    input  logic [trb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] frame_out, [48:1] frame_stamp, [49] stamp_found, [50] overflow,
    // [56:51] fill_count, rest zero
    output logic [trb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata
);

    trb_pkg::in_item_t                in_item;
    trb_pkg::ram_req_t                ram_req;
    logic [trb_pkg::STAMP_BITS-1:0]   ram_rdata;
    trb_pkg::result_t                 res;
    logic                             res_load;
    logic                             res_ready;

    assign in_item.resync          = s_axis_tdata[0];
    assign in_item.stamp_valid     = s_axis_tdata[1];
    assign in_item.stamp           =
        s_axis_tdata[trb_pkg::IN_STAMP_LO +: trb_pkg::STAMP_BITS];
    assign in_item.frame_delivered = s_axis_tdata[trb_pkg::IN_FDEL];
    assign in_item.lag_valid       = s_axis_tdata[trb_pkg::IN_LVALID];
    assign in_item.decoder_lag     =
        s_axis_tdata[trb_pkg::IN_LAG_LO +: trb_pkg::LAG_BITS];

    // sorted stamp store, one write and one registered read per cycle
    trb_ram #(
        .WIDTH (trb_pkg::STAMP_BITS),
        .DEPTH (trb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    trb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    trb_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .can_load (res_ready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

    localparam logic [trb_pkg::STAMP_BITS-1:0] STAMP_MAX =
        {1'b0, {(trb_pkg::STAMP_BITS-1){1'b1}}};
    localparam logic [trb_pkg::STAMP_BITS-1:0] STAMP_MIN =
        {1'b1, {(trb_pkg::STAMP_BITS-1){1'b0}}};
    localparam logic [trb_pkg::STAMP_BITS-1:0] STAMP_NEG1 =
        {trb_pkg::STAMP_BITS{1'b1}};
    localparam int IDLE_PCT = 37;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 145;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [trb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [trb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_we = 1'b0;
    logic                            cfg_wdata = 1'b0;

    // shadow copy of the sorted store, largest stamp first
    logic signed [trb_pkg::STAMP_BITS-1:0] shadow [trb_pkg::DEPTH];
    int       held = 0;
    bit       reorder_on = 1'b0;
    bit       calm = 1'b0;

    trb_pkg::in_item_t packet_queue [$];
    trb_pkg::result_t  due_results [$];

    int n_fail = 0;
    int n_packets = 0;
    int n_resyncs = 0;
    int n_results = 0;
    int n_stamped = 0;
    int n_overflows = 0;

    timestamp_reorder_buffer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // order per packet: resync, insert after equal entries, pop smallest, lag trim
    function automatic trb_pkg::result_t reorder_predict(trb_pkg::in_item_t it);
        logic signed [trb_pkg::STAMP_BITS-1:0] st;
        int               pos;
        trb_pkg::result_t r;
        r = '0;
        st = it.stamp;
        if (it.resync)
            held = 0;
        if (reorder_on && it.stamp_valid)
        begin
            if (held >= trb_pkg::DEPTH)
                r.overflow = 1'b1;
            else
            begin
                pos = 0;
                while (pos < held && !(shadow[pos] < st))
                    pos++;
                for (int k = held; k > pos; k--)
                    shadow[k] = shadow[k-1];
                shadow[pos] = st;
                held++;
            end
        end
        if (reorder_on && it.frame_delivered)
        begin
            if (held > 0)
            begin
                held--;
                r.frame_stamp = shadow[held];
                r.stamp_found = 1'b1;
            end
            if (it.lag_valid && int'(it.decoder_lag) <= held)
                held = int'(it.decoder_lag);
        end
        r.frame_out = it.frame_delivered;
        r.fill_count = trb_pkg::FILL_BITS'(held);
        return r;
    endfunction

    function automatic trb_pkg::in_item_t pkt(bit rs, bit sv,
                                              logic [trb_pkg::STAMP_BITS-1:0] st,
                                              bit fd, bit lv,
                                              logic [trb_pkg::LAG_BITS-1:0] lag);
        trb_pkg::in_item_t it;
        it.resync = rs;
        it.stamp_valid = sv;
        it.stamp = st;
        it.frame_delivered = fd;
        it.lag_valid = lv;
        it.decoder_lag = lag;
        return it;
    endfunction

    // fill mix drives the store into overflow; drain mix empties it and trims
    function automatic trb_pkg::in_item_t make_packet(traffic_mix_t mix);
        logic signed [trb_pkg::STAMP_BITS-1:0] s;
        int                pv;
        int                pf;
        int                pr;
        int                pl;
        int                roll;
        trb_pkg::in_item_t it;
        case (mix)
            MIX_FILL:  begin pv = 92; pf = 12; pr = 1; pl = 15; end
            MIX_DRAIN: begin pv = 45; pf = 85; pr = 3; pl = 40; end
            default:   begin pv = 70; pf = 65; pr = 3; pl = 25; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            // narrow window so equal stamps are common
            s = trb_pkg::STAMP_BITS'($urandom_range(0, 15));
            s = s - trb_pkg::STAMP_BITS'(8);
        end
        else if (roll < 85)
            s = trb_pkg::STAMP_BITS'({$urandom, $urandom});
        else
        begin
            case ($urandom_range(0, 3))
                0:       s = STAMP_MAX;
                1:       s = STAMP_MIN;
                2:       s = '0;
                default: s = STAMP_NEG1;
            endcase
        end
        it.resync = ($urandom_range(0, 99) < pr);
        it.stamp_valid = ($urandom_range(0, 99) < pv);
        it.stamp = s;
        it.frame_delivered = ($urandom_range(0, 99) < pf);
        it.lag_valid = ($urandom_range(0, 99) < pl);
        if ($urandom_range(0, 99) < 70)
            it.decoder_lag = trb_pkg::LAG_BITS'($urandom_range(0, 40));
        else
            it.decoder_lag = trb_pkg::LAG_BITS'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // driver: hold the item while stalled, otherwise present the next one or idle
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            if (packet_queue[0].resync)
                n_resyncs++;
            due_results.push_back(reorder_predict(packet_queue.pop_front()));
            n_packets++;
        end
        if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (rst_n && packet_queue.size() > 0
                && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= trb_pkg::IN_TDATA_W'({packet_queue[0].decoder_lag,
                                                      packet_queue[0].lag_valid,
                                                      packet_queue[0].frame_delivered,
                                                      packet_queue[0].stamp,
                                                      packet_queue[0].stamp_valid,
                                                      packet_queue[0].resync});
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor: compare each result item with the oldest expectation
    always @(posedge clk)
    begin : monitor
        trb_pkg::result_t want;
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (m_axis_tdata[trb_pkg::OUT_FOUND])
                n_stamped++;
            if (m_axis_tdata[trb_pkg::OUT_OVF])
                n_overflows++;
            if (due_results.size() == 0)
            begin
                $error("result item arrived with nothing expected: 0x%0h",
                       m_axis_tdata);
                n_fail++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("frame_out", 64'(want.frame_out), 64'(m_axis_tdata[0]));
                check_field("frame_stamp", 64'(want.frame_stamp),
                            64'(m_axis_tdata[trb_pkg::OUT_STAMP_LO +:
                                             trb_pkg::STAMP_BITS]));
                check_field("stamp_found", 64'(want.stamp_found),
                            64'(m_axis_tdata[trb_pkg::OUT_FOUND]));
                check_field("overflow", 64'(want.overflow),
                            64'(m_axis_tdata[trb_pkg::OUT_OVF]));
                check_field("fill_count", 64'(want.fill_count),
                            64'(m_axis_tdata[trb_pkg::OUT_FILL_LO +:
                                             trb_pkg::FILL_BITS]));
            end
        end
    end

    // wait until every packet is taken and every result has come back
    task automatic drain();
        @(negedge clk);
        while (packet_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_reorder(input bit on);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we <= 1'b0;
        reorder_on = on;
        @(negedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < trb_pkg::DEPTH; i++)
            shadow[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // disabled after reset: nothing stored, nothing popped
        packet_queue.push_back(pkt(0, 1, 48'd100, 1, 1, 8'd0));
        packet_queue.push_back(pkt(1, 1, STAMP_MAX, 1, 0, 8'd0));
        drain();

        set_reorder(1'b1);
        packet_queue.push_back(pkt(0, 1, STAMP_MAX, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, STAMP_MIN, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, 48'd0, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, STAMP_NEG1, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, 48'd0, 0, 0, 8'd0));     // equal entry
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 0, 8'd0));     // pops the minimum
        packet_queue.push_back(pkt(0, 1, 48'd7, 1, 0, 8'd0));     // insert and pop together
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 1, 8'd255));   // lag above count: kept
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 1, 8'd1));     // lag trims
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 0, 8'd0));
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 1, 8'd0));     // empty: no stamp
        packet_queue.push_back(pkt(0, 1, 48'd3, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, 48'd3, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 1, 48'd3, 0, 0, 8'd0));
        packet_queue.push_back(pkt(0, 0, 48'd0, 1, 1, 8'd0));     // trim to zero
        packet_queue.push_back(pkt(0, 1, 48'd9, 0, 0, 8'd0));
        packet_queue.push_back(pkt(1, 1, 48'd4, 1, 0, 8'd0));     // resync, insert, pop
        packet_queue.push_back(pkt(0, 1, STAMP_MIN, 0, 1, 8'd0)); // lag ignored without frame
        packet_queue.push_back(pkt(1, 0, 48'd0, 1, 1, 8'd255));
        drain();

        set_reorder(1'b0);
        packet_queue.push_back(pkt(0, 1, 48'd5, 1, 1, 8'd0));
        packet_queue.push_back(pkt(1, 0, 48'd0, 0, 0, 8'd0));     // resync works while off
        drain();

        for (int p = 0; p < 10; p++)
        begin
            set_reorder(!(p == 3 || p == 7));
            calm = (p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
                packet_queue.push_back(make_packet(traffic_mix_t'(p % 3)));
            drain();
        end
        calm = 1'b0;

        $display("run covered %0d packets (%0d resyncs) and %0d results:", n_packets,
                 n_resyncs, n_results);
        $display("  %0d frames got a stored stamp, %0d stamps dropped on a full store",
                 n_stamped, n_overflows);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
